// ===== src/max_cross_run_length_core_assert.svh =====
// ----------------------------------------------------------------------------
// Max cross run length assertion macros
// Shared concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef MAX_CROSS_RUN_LENGTH_CORE_ASSERT_SVH
`define MAX_CROSS_RUN_LENGTH_CORE_ASSERT_SVH

// clocked assertion, off during reset
`define MCR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked assertion, also checked during reset
`define MCR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/mcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Max cross run length package
// Sizes, widths and register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcr_pkg;

  localparam int unsigned MAX_ROWS = 1024;
  localparam int unsigned MAX_COLS = 1024;

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned DEPTH  = 2 ** ADDR_W;
  localparam int unsigned CNT_W  = ((ROW_W > COL_W) ? ROW_W : COL_W) + 1;
  localparam int unsigned CFG_W  = 11;
  localparam int unsigned OUT_W  = 11;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_GRID_HEIGHT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GRID_WIDTH  = IDX_W'(1);

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  function automatic logic [CNT_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned top);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > top) begin
      r = CNT_W'(top);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== src/mcr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== src/max_cross_run_length_core.sv =====
// ----------------------------------------------------------------------------
// Max cross run length core
// Greatest row-plus-column free run through a free cell of a binary grid.
// ----------------------------------------------------------------------------
// Cells are taken one per cycle in row-major order while busy_o is low. The
// last cell of the grid starts a scan of the stored bitmap, during which
// busy_o is high: a row pass reads and evaluates each cell and writes each
// free run's length into the span memory once per free cell (span write),
// then a column pass reads and evaluates each cell and, per free cell, reads
// its row span and compares the cross sum (span read and compare). The cell
// and span memories each have one read port. One result then appears on
// max_lit_o with done_o high for a single cycle; it cannot be held off, so
// the receiver must take it there and then. A grid size write restarts the grid.
`timescale 1ns / 1ps

module max_cross_run_length_core
  import mcr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             cell_blocked_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [OUT_W-1:0] max_lit_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  `include "max_cross_run_length_core_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE, ST_H_RD, ST_H_EV, ST_H_FILL, ST_V_RD, ST_V_EV, ST_V_SRD, ST_V_SEV
  } state_e;

  state_e           state_q;
  logic [CFG_W-1:0] height_q, width_q;
  logic [CNT_W-1:0] in_row_q, in_col_q;
  logic [CNT_W-1:0] r_q, c_q, a_q, e_q, k_q;
  logic             run_q;
  logic [OUT_W-1:0] best_q;
  logic             done_q;
  logic [OUT_W-1:0] max_lit_q;

  logic [CNT_W-1:0] h_eff, w_eff;
  logic             accept;
  logic             last_cell;

  logic              cell_we;
  logic [ADDR_W-1:0] cell_waddr, cell_raddr;
  logic              cell_rdata;
  logic              span_we;
  logic [ADDR_W-1:0] span_waddr, span_raddr;
  logic [CNT_W-1:0]  span_wdata, span_rdata;
  logic [CNT_W:0]    sum;

  assign h_eff     = clamp_size(height_q, MAX_ROWS);
  assign w_eff     = clamp_size(width_q, MAX_COLS);
  assign accept    = start_i && (state_q == ST_IDLE);
  assign last_cell = (in_col_q + CNT_W'(1) == w_eff) && (in_row_q + CNT_W'(1) == h_eff);

  assign cell_we    = accept;
  assign cell_waddr = {in_row_q[ROW_W-1:0], in_col_q[COL_W-1:0]};
  assign cell_raddr = {r_q[ROW_W-1:0], c_q[COL_W-1:0]};

  assign span_we    = (state_q == ST_H_FILL);
  assign span_waddr = {r_q[ROW_W-1:0], k_q[COL_W-1:0]};
  assign span_wdata = e_q - a_q;
  assign span_raddr = {k_q[ROW_W-1:0], c_q[COL_W-1:0]};

  assign sum = {1'b0, span_rdata} + {1'b0, e_q - a_q} - (CNT_W+1)'(1);

  mcr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (cell_waddr),
    .wdata_i (cell_blocked_i),
    .raddr_i (cell_raddr),
    .rdata_o (cell_rdata)
  );

  mcr_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (span_we),
    .waddr_i (span_waddr),
    .wdata_i (span_wdata),
    .raddr_i (span_raddr),
    .rdata_o (span_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      height_q  <= CFG_RESET;
      width_q   <= CFG_RESET;
      in_row_q  <= '0;
      in_col_q  <= '0;
      r_q       <= '0;
      c_q       <= '0;
      a_q       <= '0;
      e_q       <= '0;
      k_q       <= '0;
      run_q     <= 1'b0;
      best_q    <= '0;
      done_q    <= 1'b0;
      max_lit_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GRID_HEIGHT: begin
            height_q <= cfg_data_i;
            in_row_q <= '0;
            in_col_q <= '0;
          end
          REG_GRID_WIDTH: begin
            width_q  <= cfg_data_i;
            in_row_q <= '0;
            in_col_q <= '0;
          end
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (in_col_q + CNT_W'(1) < w_eff) begin
              in_col_q <= in_col_q + CNT_W'(1);
            end else begin
              in_col_q <= '0;
              in_row_q <= last_cell ? '0 : in_row_q + CNT_W'(1);
            end
            if (last_cell) begin
              state_q <= ST_H_RD;
              r_q     <= '0;
              c_q     <= '0;
              run_q   <= 1'b0;
              best_q  <= '0;
            end
          end
        end
        ST_H_RD: begin
          if (c_q == w_eff) begin
            if (run_q) begin
              run_q   <= 1'b0;
              e_q     <= c_q;
              k_q     <= a_q;
              state_q <= ST_H_FILL;
            end else if (r_q + CNT_W'(1) == h_eff) begin
              r_q     <= '0;
              c_q     <= '0;
              state_q <= ST_V_RD;
            end else begin
              r_q <= r_q + CNT_W'(1);
              c_q <= '0;
            end
          end else begin
            state_q <= ST_H_EV;
          end
        end
        ST_H_EV: begin
          c_q <= c_q + CNT_W'(1);
          if (cell_rdata) begin
            if (run_q) begin
              run_q   <= 1'b0;
              e_q     <= c_q;
              k_q     <= a_q;
              state_q <= ST_H_FILL;
            end else begin
              state_q <= ST_H_RD;
            end
          end else begin
            if (!run_q) begin
              a_q   <= c_q;
              run_q <= 1'b1;
            end
            state_q <= ST_H_RD;
          end
        end
        ST_H_FILL: begin
          k_q <= k_q + CNT_W'(1);
          if (k_q + CNT_W'(1) == e_q) begin
            state_q <= ST_H_RD;
          end
        end
        ST_V_RD: begin
          if (r_q == h_eff) begin
            if (run_q) begin
              run_q   <= 1'b0;
              e_q     <= r_q;
              k_q     <= a_q;
              state_q <= ST_V_SRD;
            end else if (c_q + CNT_W'(1) == w_eff) begin
              done_q    <= 1'b1;
              max_lit_q <= best_q;
              state_q   <= ST_IDLE;
            end else begin
              c_q <= c_q + CNT_W'(1);
              r_q <= '0;
            end
          end else begin
            state_q <= ST_V_EV;
          end
        end
        ST_V_EV: begin
          r_q <= r_q + CNT_W'(1);
          if (cell_rdata) begin
            if (run_q) begin
              run_q   <= 1'b0;
              e_q     <= r_q;
              k_q     <= a_q;
              state_q <= ST_V_SRD;
            end else begin
              state_q <= ST_V_RD;
            end
          end else begin
            if (!run_q) begin
              a_q   <= r_q;
              run_q <= 1'b1;
            end
            state_q <= ST_V_RD;
          end
        end
        ST_V_SRD: begin
          state_q <= ST_V_SEV;
        end
        ST_V_SEV: begin
          if (sum > (CNT_W+1)'({OUT_W{1'b1}})) begin
            best_q <= {OUT_W{1'b1}};
          end else if (OUT_W'(sum) > best_q) begin
            best_q <= OUT_W'(sum);
          end
          k_q <= k_q + CNT_W'(1);
          state_q <= (k_q + CNT_W'(1) == e_q) ? ST_V_RD : ST_V_SRD;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign done_o    = done_q;
  assign max_lit_o = max_lit_q;

  `MCR_ASSERT(a_done_after_scan, done_o |-> $past(busy_o), "result without a scan")
  `MCR_ASSERT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `MCR_ASSERT(a_start_scan, (accept && last_cell) |=> busy_o, "scan did not start")
  `MCR_ASSERT_ALWAYS(a_done_idle, done_o |-> !busy_o, "result while busy")

endmodule
